// File: rtl/core/mexp_pkg.sv
// types and constants shared by the modular exponentiation block
`default_nettype none

package mexp_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/modular_exponentiation_top.sv
// modular exponentiation, right-to-left square-and-multiply on one shared modmul unit
// throughput: one item at a time; each modular multiply steps through the
//   shared shift-add-reduce unit, which handles one multiplier bit per cycle
// reset: rst_n synchronous active low clears the sequencer and output valid, modulus goes to 1
`default_nettype none

module modular_exponentiation_top #(
  parameter int OPERAND_WIDTH = 32,
  localparam int InTdataW  = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
  localparam int OutTdataW = ((OPERAND_WIDTH + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_wr_en,
  input  wire logic [OPERAND_WIDTH-1:0] cfg_wr_data,    // modulus
  // input stream
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [InTdataW-1:0]      in_tdata,       // base_value, exponent_value
  // result stream
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OutTdataW-1:0]          out_tdata       // power_result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(OPERAND_WIDTH);

  mexp_pkg::state_t state_r, state_nxt;

  logic [W-1:0]  mod_r;
  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  sq_r, sq_nxt;
  logic [W-1:0]  result_r, result_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  mplier_r, mplier_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_data_r, out_data_nxt;

  logic [W-1:0]  in_base;
  logic [W-1:0]  in_exp;
  logic          in_beat;

  logic [W-1:0]  addend;
  logic [W+1:0]  sum;
  logic [W+1:0]  mod_x1;
  logic [W+1:0]  mod_x2;
  logic [W-1:0]  red;

  assign in_base = in_tdata[W-1:0];
  assign in_exp  = in_tdata[2*W-1:W];
  assign in_beat = in_tvalid && in_tready;

  // shared unit: acc*2 + addend reduced mod m, sum stays below 3m
  always_comb begin
    if (state_r == mexp_pkg::ST_REDUCE) begin
      addend = {{(W-1){1'b0}}, mplier_r[W-1]};
    end else begin
      addend = mplier_r[W-1] ? sq_r : '0;
    end
    sum    = {1'b0, acc_r, 1'b0} + {2'b00, addend};
    mod_x1 = {2'b00, mod_r};
    mod_x2 = {1'b0, mod_r, 1'b0};
    if (sum >= mod_x2) begin
      red = W'(sum - mod_x2);
    end else if (sum >= mod_x1) begin
      red = W'(sum - mod_x1);
    end else begin
      red = W'(sum);
    end
  end

  // sequencer and next values
  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    sq_nxt        = sq_r;
    result_nxt    = result_r;
    acc_nxt       = acc_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_beat) begin
          exp_nxt    = in_exp;
          mplier_nxt = in_base;
          acc_nxt    = '0;
          cnt_nxt    = CW'(W - 1);
          if (in_exp == '0) begin
            // zero exponent gives 1 with no reduction
            result_nxt = W'(1);
            state_nxt  = mexp_pkg::ST_FINISH;
          end else begin
            result_nxt = (mod_r == W'(1)) ? '0 : W'(1);
            state_nxt  = mexp_pkg::ST_REDUCE;
          end
        end
      end

      mexp_pkg::ST_REDUCE: begin
        acc_nxt    = red;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sq_nxt  = red;
          acc_nxt = '0;
          cnt_nxt = CW'(W - 1);
          if (exp_r[0]) begin
            mplier_nxt = result_r;
            state_nxt  = mexp_pkg::ST_MUL;
          end else begin
            mplier_nxt = red;
            state_nxt  = mexp_pkg::ST_SQR;
          end
        end
      end

      mexp_pkg::ST_MUL: begin
        acc_nxt    = red;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          result_nxt = red;
          acc_nxt    = '0;
          cnt_nxt    = CW'(W - 1);
          mplier_nxt = sq_r;
          // no higher exponent bits left: the last square is not needed
          if (exp_r[W-1:1] == '0) begin
            state_nxt = mexp_pkg::ST_FINISH;
          end else begin
            state_nxt = mexp_pkg::ST_SQR;
          end
        end
      end

      mexp_pkg::ST_SQR: begin
        acc_nxt    = red;
        mplier_nxt = mplier_r << 1;
        cnt_nxt    = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          sq_nxt  = red;
          exp_nxt = exp_r >> 1;
          acc_nxt = '0;
          cnt_nxt = CW'(W - 1);
          if (exp_r[1]) begin
            mplier_nxt = result_r;
            state_nxt  = mexp_pkg::ST_MUL;
          end else begin
            mplier_nxt = red;
            state_nxt  = mexp_pkg::ST_SQR;
          end
        end
      end

      mexp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // a zero modulus write is dropped
      if (cfg_wr_en && (cfg_wr_data != '0)) begin
        mod_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    exp_r      <= exp_nxt;
    sq_r       <= sq_nxt;
    result_r   <= result_nxt;
    acc_r      <= acc_nxt;
    mplier_r   <= mplier_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == mexp_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutTdataW'(out_data_r);

  // modulus never holds zero
  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mod_r != '0)
    else $error("modulus register holds zero");

  // operands of the shared unit stay reduced while multiplying
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_MUL || state_r == mexp_pkg::ST_SQR) |->
      (sq_r < mod_r && acc_r < mod_r && result_r < mod_r))
    else $error("modmul operand not reduced");

  // zero exponent skips the multiply sequence
  a_zero_exp_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_exp == '0) |=> (state_r == mexp_pkg::ST_FINISH && result_r == W'(1)))
    else $error("zero exponent did not finish at once");

endmodule

`default_nettype wire

// File: sim/tb_modular_exponentiation_top.sv
// testbench for the modular exponentiation block: directed, back-pressure and random checks
`default_nettype none

module tb_modular_exponentiation_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OperandW = 32;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [OperandW-1:0] cfg_wr_data = '0;      // modulus
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata = '0;         // base_value, exponent_value
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;             // power_result

  // predictor copy of the modulus register
  logic [OperandW-1:0] modulus_reg = 32'd1;
  logic [OperandW-1:0] expected_powers[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int results_checked = 0;
  int modulus_writes = 0;
  int mismatch_count = 0;

  modular_exponentiation_top #(.OPERAND_WIDTH(OperandW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // b^e mod m by right-to-left square-and-multiply, products kept at double width
  function automatic logic [OperandW-1:0] mod_power(input logic [OperandW-1:0] b,
                                                    input logic [OperandW-1:0] e,
                                                    input logic [OperandW-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    if (e == '0) return 32'd1;
    sq  = {32'd0, b} % {32'd0, m};
    acc = 64'd1 % {32'd0, m};
    for (int i = 0; i < OperandW; i++) begin
      if (e[i]) acc = (acc * sq) % {32'd0, m};
      sq = (sq * sq) % {32'd0, m};
    end
    return acc[OperandW-1:0];
  endfunction

  // receiver: long hold when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // result checker: compare each accepted beat with the oldest expected power
  always @(posedge clk) begin
    logic [OperandW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_powers.size() == 0) begin
        $error("power_result: no result expected, actual %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_powers.pop_front();
        if (out_tdata !== want) begin
          $error("power_result: expected %h, actual %h", want, out_tdata);
          mismatch_count++;
        end
      end
      results_checked++;
    end
  end

  // offer one beat, with random idle cycles ahead of it; valid stays high on exit
  task automatic send_item(input logic [OperandW-1:0] b, input logic [OperandW-1:0] e);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e, b};
    do @(posedge clk); while (!in_tready);
    expected_powers.push_back(mod_power(b, e, modulus_reg));
    items_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // modulus write while the block is idle; a zero is dropped by the block
  task automatic set_modulus(input logic [OperandW-1:0] m);
    stop_input();
    wait_drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    if (m != '0) modulus_reg = m;
    modulus_writes++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // modulus of one after reset: zero exponent gives 1, anything else gives 0
  task automatic test_reset_modulus();
    send_item(32'd7, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'd7, 32'd5);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // field extremes and the special cases
  task automatic test_directed();
    set_modulus(32'hFFFF_FFFF);
    send_item(32'd0, 32'd0);
    send_item(32'd0, 32'd1);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(32'd2, 32'd31);
    send_item(32'd3, 32'hFFFF_FFFF);
    send_item(32'd1, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000);
    // zero write must leave the modulus alone
    set_modulus(32'd13);
    set_modulus(32'd0);
    send_item(32'hFFFF_FFFF, 32'd12);
    send_item(32'd26, 32'd3);
    send_item(32'd5, 32'd0);
    set_modulus(32'h8000_0000);
    send_item(32'd3, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd2);
    // modulus of one again, zero exponent still gives 1
    set_modulus(32'd1);
    send_item(32'd9, 32'd0);
    send_item(32'd9, 32'd9);
    set_modulus(32'hFFFF_FFFB);
    send_item(32'hFFFF_FFFA, 32'hFFFF_FFFA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    stop_input();
  endtask

  // receiver held off while the sender keeps offering, so the input must stall
  task automatic test_backpressure();
    set_modulus(32'd1_000_003);
    set_idle(0, 0);
    hold_left = 1500;
    repeat (10) send_item($urandom, $urandom_range(15, 1));
    stop_input();
    wait_drain();
  endtask

  // random items; modulus changes every so often, most exponents short
  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    logic [OperandW-1:0] b;
    logic [OperandW-1:0] e;
    logic [OperandW-1:0] m;
    int bits;
    set_idle(send_pct, recv_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 18 == 0) begin
        case ($urandom_range(5, 0))
          0: m = 32'hFFFF_FFFF;
          1: m = 32'd1;
          2: m = 32'd1 << $urandom_range(31, 0);
          3: m = $urandom_range(65535, 2);
          default: m = $urandom;
        endcase
        set_modulus(m);
      end
      b = $urandom;
      case ($urandom_range(9, 0))
        0: e = 32'd0;
        1: e = 32'hFFFF_FFFF;
        2, 3, 4: e = $urandom;
        default: begin
          bits = $urandom_range(8, 1);
          e = ($urandom >> (32 - bits)) | (32'd1 << (bits - 1));
        end
      endcase
      send_item(b, e);
    end
    stop_input();
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_modulus();
    test_directed();
    test_backpressure();
    test_random(70, 0, 0);
    test_random(70, 66, 0);
    test_random(70, 0, 66);
    test_random(70, 28, 28);

    stop_input();
    wait_drain();
    repeat (2100) @(posedge clk);

    $display("checked %0d results from %0d beats across %0d modulus writes,",
             results_checked, items_sent, modulus_writes);
    $display("with zero exponents, unit and power-of-two moduli, stalls and a long hold");
    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
